>>> hdl/frustum_box_cull_defines.svh
// ----------------------------------------------------------------------------
// frustum_box_cull assertion macros
// shared concurrent assertion forms for the culling block
// ----------------------------------------------------------------------------
`ifndef FRUSTUM_BOX_CULL_DEFINES_SVH
`define FRUSTUM_BOX_CULL_DEFINES_SVH

// same-cycle implication
`define FBC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: %m");

// next-cycle implication
`define FBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: %m");

`endif

>>> hdl/fbc_pkg.sv
// ----------------------------------------------------------------------------
// fbc_pkg
// types and constants shared by the frustum culling cells and top level
// ----------------------------------------------------------------------------
package fbc_pkg;

  localparam int unsigned PLANE_COUNT = 6;
  localparam int unsigned COEFF_COUNT = 4;
  localparam int unsigned AXES        = 3;
  localparam int unsigned WORDS       = 6;

  localparam logic [1:0] COEFF_W = 2'd3;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TEST = 1'b1
  } opcode_e;

  typedef struct packed {
    logic       valid;
    opcode_e    op;
    logic [1:0] cidx;
    logic       vis;
  } ctl_t;

endpackage

>>> hdl/fbc_cell.sv
// ----------------------------------------------------------------------------
// fbc_cell
// one frustum plane: holds its four coefficients, applies column loads and
// tests the positive box vertex over three stages
// ----------------------------------------------------------------------------
module fbc_cell #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned PLANE_IDX  = 0
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        en_i,
  input  fbc_pkg::ctl_t                               ctl_i,
  input  logic [fbc_pkg::WORDS-1:0][DATA_WIDTH-1:0]   data_i,
  output fbc_pkg::ctl_t                               ctl_o,
  output logic [fbc_pkg::WORDS-1:0][DATA_WIDTH-1:0]   data_o
);
  import fbc_pkg::*;

  localparam int unsigned CW = DATA_WIDTH + 1;
  localparam int unsigned HW = DATA_WIDTH / 2;
  localparam int unsigned LW = CW + HW + 1;
  localparam int unsigned UW = CW + DATA_WIDTH - HW;
  localparam int unsigned SW = 2 * DATA_WIDTH + 3;
  localparam logic [2:0]  ROW = 3'(PLANE_IDX / 2);
  localparam logic        SUB = 1'(PLANE_IDX % 2);

  logic signed [CW-1:0] coeff_q [COEFF_COUNT];
  logic signed [CW-1:0] e_w, e_r, coeff_new;

  logic [DATA_WIDTH-1:0]      vert [AXES];
  logic signed [HW:0]         vl   [AXES];
  logic signed [DATA_WIDTH-HW-1:0] vh [AXES];

  logic signed [LW-1:0] p_lo_d [AXES];
  logic signed [LW-1:0] p_lo_q [AXES];
  logic signed [UW-1:0] p_hi_d [AXES];
  logic signed [UW-1:0] p_hi_q [AXES];
  logic signed [SW-1:0] w_sh_d, w_sh_q;
  logic signed [SW-1:0] axis_d [AXES];
  logic signed [SW-1:0] axis_q [AXES];
  logic signed [SW-1:0] sum;

  ctl_t ctl1_q, ctl2_q, ctl3_q, ctl3_d;
  logic [WORDS-1:0][DATA_WIDTH-1:0] data1_q, data2_q, data3_q;

  // column load
  assign e_w       = CW'($signed(data_i[{1'b0, COEFF_W}]));
  assign e_r       = CW'($signed(data_i[ROW]));
  assign coeff_new = SUB ? (e_w - e_r) : (e_w + e_r);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < COEFF_COUNT; i++) begin
        coeff_q[i] <= '0;
      end
    end else if (en_i && ctl_i.valid && (ctl_i.op == OP_LOAD)) begin
      coeff_q[ctl_i.cidx] <= coeff_new;
    end
  end

  // positive vertex and split products
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      vert[a]   = coeff_q[a][CW-1] ? data_i[a] : data_i[a+AXES];
      vl[a]     = $signed({1'b0, vert[a][HW-1:0]});
      vh[a]     = $signed(vert[a][DATA_WIDTH-1:HW]);
      p_lo_d[a] = coeff_q[a] * vl[a];
      p_hi_d[a] = coeff_q[a] * vh[a];
    end
  end

  assign w_sh_d = SW'(coeff_q[COEFF_W]) <<< HW;

  // per-axis products, w term folded into x
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      axis_d[a] = (SW'(p_hi_q[a]) <<< HW) + SW'(p_lo_q[a])
                + ((a == 0) ? w_sh_q : SW'(0));
    end
  end

  assign sum = axis_q[0] + axis_q[1] + axis_q[2];

  always_comb begin
    ctl3_d     = ctl2_q;
    ctl3_d.vis = ctl2_q.vis & ~sum[SW-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      ctl3_q <= '0;
    end else if (en_i) begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
      ctl3_q <= ctl3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data1_q <= data_i;
      data2_q <= data1_q;
      data3_q <= data2_q;
      w_sh_q  <= w_sh_d;
      for (int a = 0; a < AXES; a++) begin
        p_lo_q[a] <= p_lo_d[a];
        p_hi_q[a] <= p_hi_d[a];
        axis_q[a] <= axis_d[a];
      end
    end
  end

  assign ctl_o  = ctl3_q;
  assign data_o = data3_q;

endmodule

>>> hdl/frustum_box_cull.sv
// ----------------------------------------------------------------------------
// frustum_box_cull
// six-plane view-frustum culling of axis-aligned boxes, planes formed from
// projection-view matrix columns and held in a chain of plane cells
//
// channel  direction  handshake              payload
// in       input      in_valid_i/in_stall_o  opcode, column_index, col_entry_*, min_*, max_*
// out      output     out_valid_o/out_stall_i visible
//
// one transaction per cycle in while in_stall_o is low; each plane cell is registered
// a test passes the plane cells and then the output register; loads give no result
// reset clears all plane coefficients, so every box reads visible until loaded
// output register plus one skid entry; in_stall_o rises only when the skid is full
// ----------------------------------------------------------------------------
`include "frustum_box_cull_defines.svh"

module frustum_box_cull #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         opcode_i,
  input  logic [1:0]                   column_index_i,
  input  logic signed [DATA_WIDTH-1:0] col_entry_0_i,
  input  logic signed [DATA_WIDTH-1:0] col_entry_1_i,
  input  logic signed [DATA_WIDTH-1:0] col_entry_2_i,
  input  logic signed [DATA_WIDTH-1:0] col_entry_3_i,
  input  logic signed [DATA_WIDTH-1:0] min_x_i,
  input  logic signed [DATA_WIDTH-1:0] min_y_i,
  input  logic signed [DATA_WIDTH-1:0] min_z_i,
  input  logic signed [DATA_WIDTH-1:0] max_x_i,
  input  logic signed [DATA_WIDTH-1:0] max_y_i,
  input  logic signed [DATA_WIDTH-1:0] max_z_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         visible_o
);
  import fbc_pkg::*;

  ctl_t                             ctl_chain  [PLANE_COUNT+1];
  logic [WORDS-1:0][DATA_WIDTH-1:0] data_chain [PLANE_COUNT+1];

  logic en;
  logic res_valid, take;
  logic out_valid_q, out_valid_d, out_vis_q, out_vis_d;
  logic skid_valid_q, skid_valid_d, skid_vis_q, skid_vis_d;

  assign en         = ~skid_valid_q;
  assign in_stall_o = skid_valid_q;

  always_comb begin
    ctl_chain[0].valid = in_valid_i;
    ctl_chain[0].op    = opcode_e'(opcode_i);
    ctl_chain[0].cidx  = column_index_i;
    ctl_chain[0].vis   = 1'b1;
    if (opcode_e'(opcode_i) == OP_TEST) begin
      data_chain[0] = {max_z_i, max_y_i, max_x_i, min_z_i, min_y_i, min_x_i};
    end else begin
      data_chain[0] = {{(2*DATA_WIDTH){1'b0}},
                       col_entry_3_i, col_entry_2_i, col_entry_1_i, col_entry_0_i};
    end
  end

  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
    fbc_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .PLANE_IDX (p)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .ctl_i (ctl_chain[p]),
      .data_i(data_chain[p]),
      .ctl_o (ctl_chain[p+1]),
      .data_o(data_chain[p+1])
    );
  end

  assign res_valid = ctl_chain[PLANE_COUNT].valid && (ctl_chain[PLANE_COUNT].op == OP_TEST);
  assign take      = res_valid && en;

  // output register and skid entry
  always_comb begin
    out_valid_d  = out_valid_q;
    out_vis_d    = out_vis_q;
    skid_valid_d = skid_valid_q;
    skid_vis_d   = skid_vis_q;
    if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_vis_d    = skid_vis_q;
        skid_valid_d = 1'b0;
      end else if (take) begin
        out_valid_d = 1'b1;
        out_vis_d   = ctl_chain[PLANE_COUNT].vis;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (take) begin
      skid_valid_d = 1'b1;
      skid_vis_d   = ctl_chain[PLANE_COUNT].vis;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_vis_q  <= out_vis_d;
    skid_vis_q <= skid_vis_d;
  end

  assign out_valid_o = out_valid_q;
  assign visible_o   = out_vis_q;

  `FBC_ASSERT_IMP(a_skid_needs_main, clk_i, rst_ni, skid_valid_q, out_valid_q)
  `FBC_ASSERT_NEXT(a_skid_holds, clk_i, rst_ni, skid_valid_q && out_stall_i, skid_valid_q)
  `FBC_ASSERT_NEXT(a_result_kept, clk_i, rst_ni, take && out_valid_q && out_stall_i, skid_valid_q)

endmodule

>>> tb/frustum_box_cull_checker.sv
// ----------------------------------------------------------------------------
// frustum_box_cull_checker
// watches both channels of the culling block, keeps its own copy of the six
// frustum planes, predicts the visible flag of every box test and compares it
// with each result transaction in order
// ----------------------------------------------------------------------------
module frustum_box_cull_checker #(
  parameter int unsigned DW = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic                 opcode_i,
  input  logic [1:0]           column_index_i,
  input  logic signed [DW-1:0] col_entry_0_i,
  input  logic signed [DW-1:0] col_entry_1_i,
  input  logic signed [DW-1:0] col_entry_2_i,
  input  logic signed [DW-1:0] col_entry_3_i,
  input  logic signed [DW-1:0] min_x_i,
  input  logic signed [DW-1:0] min_y_i,
  input  logic signed [DW-1:0] min_z_i,
  input  logic signed [DW-1:0] max_x_i,
  input  logic signed [DW-1:0] max_y_i,
  input  logic signed [DW-1:0] max_z_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic                 visible_i,
  output int                   mismatch_count_o,
  output int                   pending_o,
  output int                   load_count_o,
  output int                   visible_count_o,
  output int                   culled_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import fbc_pkg::*;

  localparam int unsigned FRAC = DW / 2;
  localparam int unsigned WIDE = 2 * DW + 8;

  logic signed [DW:0] plane_coef [PLANE_COUNT][COEFF_COUNT];
  bit                 visible_expected [$];
  logic signed [DW:0] w_row;
  logic signed [DW:0] axis_row;
  bit                 want;
  int                 mismatches;
  int                 loads;
  int                 seen_visible;
  int                 seen_culled;

  assign mismatch_count_o = mismatches;
  assign load_count_o     = loads;
  assign visible_count_o  = seen_visible;
  assign culled_count_o   = seen_culled;

  // positive vertex of each plane, exact q32.32 distance, zero counts as inside
  function automatic bit frustum_admits(input logic signed [DW-1:0] lo_x, lo_y, lo_z,
                                        input logic signed [DW-1:0] hi_x, hi_y, hi_z);
    logic signed [DW-1:0]   lo [3];
    logic signed [DW-1:0]   hi [3];
    logic signed [WIDE-1:0] reach;
    logic signed [WIDE-1:0] coef;
    logic signed [WIDE-1:0] corner;
    bit                     admit;
    lo[0] = lo_x;
    lo[1] = lo_y;
    lo[2] = lo_z;
    hi[0] = hi_x;
    hi[1] = hi_y;
    hi[2] = hi_z;
    admit = 1'b1;
    for (int p = 0; p < PLANE_COUNT; p++) begin
      reach = plane_coef[p][COEFF_W];
      reach = reach <<< FRAC;
      for (int a = 0; a < AXES; a++) begin
        coef   = plane_coef[p][a];
        corner = plane_coef[p][a][DW] ? lo[a] : hi[a];
        reach  = reach + coef * corner;
      end
      if (reach < 0) admit = 1'b0;
    end
    return admit;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < PLANE_COUNT; p++)
        for (int c = 0; c < COEFF_COUNT; c++)
          plane_coef[p][c] = '0;
      visible_expected.delete();
      mismatches   = 0;
      loads        = 0;
      seen_visible = 0;
      seen_culled  = 0;
      pending_o   <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        if (opcode_i == OP_LOAD) begin
          // left, bottom, near add the row; right, top, far subtract it
          w_row = col_entry_3_i;
          for (int p = 0; p < PLANE_COUNT; p++) begin
            axis_row = (p < 2) ? col_entry_0_i : (p < 4) ? col_entry_1_i : col_entry_2_i;
            plane_coef[p][column_index_i] = (p % 2) ? w_row - axis_row : w_row + axis_row;
          end
          loads++;
        end else begin
          visible_expected.push_back(frustum_admits(min_x_i, min_y_i, min_z_i,
                                                    max_x_i, max_y_i, max_z_i));
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (visible_expected.size() == 0) begin
          $error("visible: result %0b with no transaction waiting", visible_i);
          mismatches++;
        end else begin
          want = visible_expected.pop_front();
          if (visible_i !== want) begin
            $error("visible: expected %0b, got %0b", want, visible_i);
            mismatches++;
          end
          if (want) seen_visible++;
          else seen_culled++;
        end
      end
      pending_o <= visible_expected.size();
    end
  end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// drives the frustum culling block with column loads and box tests: a short
// directed set (zero planes, zero normals, exact zero distance, extreme
// coefficients, an identity frustum) and then random frusta with random boxes,
// under random idling on both channels, a long output hold-off and one drain
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fbc_pkg::*;

  localparam int unsigned DW          = 32;
  localparam int unsigned LATENCY     = 19;
  localparam int unsigned ITEMS       = 1900;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int          ONE         = 1 << (DW / 2);
  localparam logic [1:0]  COEFF_X     = 2'd0;
  localparam logic [1:0]  COEFF_Y     = 2'd1;
  localparam logic [1:0]  COEFF_Z     = 2'd2;
  localparam logic [DW-1:0] MAXV      = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MINV      = {1'b1, {(DW-1){1'b0}}};

  typedef struct packed {
    opcode_e             op;
    logic [1:0]          col;
    logic [3:0][DW-1:0]  entry;
    logic [2:0][DW-1:0]  lo;
    logic [2:0][DW-1:0]  hi;
  } xact_t;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_stall_o;
  logic          opcode_i;
  logic [1:0]    column_index_i;
  logic [DW-1:0] col_entry_0_i;
  logic [DW-1:0] col_entry_1_i;
  logic [DW-1:0] col_entry_2_i;
  logic [DW-1:0] col_entry_3_i;
  logic [DW-1:0] min_x_i;
  logic [DW-1:0] min_y_i;
  logic [DW-1:0] min_z_i;
  logic [DW-1:0] max_x_i;
  logic [DW-1:0] max_y_i;
  logic [DW-1:0] max_z_i;
  logic          out_valid_o;
  logic          out_stall_i;
  logic          visible_o;

  int mismatch_count;
  int pending;
  int load_count;
  int visible_count;
  int culled_count;
  int n_sent;
  bit calm;
  bit rush;
  bit hold_req;

  frustum_box_cull #(
    .DATA_WIDTH (DW)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .column_index_i (column_index_i),
    .col_entry_0_i  (col_entry_0_i),
    .col_entry_1_i  (col_entry_1_i),
    .col_entry_2_i  (col_entry_2_i),
    .col_entry_3_i  (col_entry_3_i),
    .min_x_i        (min_x_i),
    .min_y_i        (min_y_i),
    .min_z_i        (min_z_i),
    .max_x_i        (max_x_i),
    .max_y_i        (max_y_i),
    .max_z_i        (max_z_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .visible_o      (visible_o)
  );

  frustum_box_cull_checker #(
    .DW (DW)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .opcode_i         (opcode_i),
    .column_index_i   (column_index_i),
    .col_entry_0_i    (col_entry_0_i),
    .col_entry_1_i    (col_entry_1_i),
    .col_entry_2_i    (col_entry_2_i),
    .col_entry_3_i    (col_entry_3_i),
    .min_x_i          (min_x_i),
    .min_y_i          (min_y_i),
    .min_z_i          (min_z_i),
    .max_x_i          (max_x_i),
    .max_y_i          (max_y_i),
    .max_z_i          (max_z_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .visible_i        (visible_o),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending),
    .load_count_o     (load_count),
    .visible_count_o  (visible_count),
    .culled_count_o   (culled_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #8_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic int small_q(input int mag);
    return int'($urandom_range(0, 2 * mag)) - mag;
  endfunction

  task automatic offer(input xact_t x);
    if (!calm && !rush && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= x.op;
    column_index_i <= x.col;
    col_entry_0_i  <= x.entry[0];
    col_entry_1_i  <= x.entry[1];
    col_entry_2_i  <= x.entry[2];
    col_entry_3_i  <= x.entry[3];
    min_x_i        <= x.lo[0];
    min_y_i        <= x.lo[1];
    min_z_i        <= x.lo[2];
    max_x_i        <= x.hi[0];
    max_y_i        <= x.hi[1];
    max_z_i        <= x.hi[2];
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    n_sent++;
  endtask

  // box fields carry noise on a load
  task automatic load_col(input logic [1:0] col,
                          input logic [DW-1:0] e0, e1, e2, e3);
    xact_t x;
    x.op    = OP_LOAD;
    x.col   = col;
    x.entry = {e3, e2, e1, e0};
    x.lo    = {$urandom, $urandom, $urandom};
    x.hi    = {$urandom, $urandom, $urandom};
    offer(x);
  endtask

  // column fields carry noise on a test
  task automatic test_box(input logic [DW-1:0] lx, ly, lz, hx, hy, hz);
    xact_t x;
    x.op    = OP_TEST;
    x.col   = 2'($urandom_range(0, 3));
    x.entry = {$urandom, $urandom, $urandom, $urandom};
    x.lo    = {lz, ly, lx};
    x.hi    = {hz, hy, hx};
    offer(x);
  endtask

  task automatic random_box();
    int unsigned style;
    int          c [3];
    int          h [3];
    style = $urandom_range(0, 15);
    for (int a = 0; a < 3; a++) begin
      c[a] = small_q(3 * ONE);
      h[a] = $urandom_range(0, ONE);
    end
    if (style == 0)
      test_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    else if (style == 1)
      test_box(c[0] + h[0], c[1] + h[1], c[2] + h[2], c[0] - h[0], c[1] - h[1], c[2] - h[2]);
    else
      test_box(c[0] - h[0], c[1] - h[1], c[2] - h[2], c[0] + h[0], c[1] + h[1], c[2] + h[2]);
  endtask

  // near-identity, small random or full-range matrix, columns sometimes skipped
  task automatic random_matrix();
    int unsigned   style;
    int unsigned   first;
    logic [DW-1:0] e [4];
    style = $urandom_range(0, 9);
    first = $urandom_range(0, 3);
    for (int k = 0; k < 4; k++) begin
      int col;
      col = (first + k) % 4;
      if ($urandom_range(0, 7) == 0) continue;
      for (int r = 0; r < 4; r++) begin
        if (style < 6)
          e[r] = (r == col ? ONE / 2 + $urandom_range(0, 2 * ONE) : 0) + small_q(ONE / 2);
        else if (style < 8)
          e[r] = small_q(4 * ONE);
        else
          e[r] = $urandom;
      end
      load_col(col[1:0], e[0], e[1], e[2], e[3]);
    end
  endtask

  initial begin
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, calm ? 1 : 12)) @(posedge clk_i);
      end
    end
  end

  initial begin
    bit held;
    bit drained;
    int n_tests;
    held     = 1'b0;
    drained  = 1'b0;
    calm     = 1'b0;
    rush     = 1'b0;
    hold_req = 1'b0;
    n_sent   = 0;
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    opcode_i       <= OP_LOAD;
    column_index_i <= '0;
    col_entry_0_i  <= '0;
    col_entry_1_i  <= '0;
    col_entry_2_i  <= '0;
    col_entry_3_i  <= '0;
    min_x_i        <= '0;
    min_y_i        <= '0;
    min_z_i        <= '0;
    max_x_i        <= '0;
    max_y_i        <= '0;
    max_z_i        <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // cleared planes: everything visible, inverted box too
    test_box(MINV, MINV, MINV, MAXV, MAXV, MAXV);
    test_box(MAXV, MAXV, MAXV, MINV, MINV, MINV);
    // zero normals, negative then zero w
    load_col(COEFF_W, 0, 0, 0, -1);
    test_box(0, 0, 0, ONE, ONE, ONE);
    load_col(COEFF_W, 0, 0, 0, 0);
    test_box(MINV, MINV, MINV, MINV, MINV, MINV);
    // distance exactly zero on the boundary, then just outside
    load_col(COEFF_X, 0, 0, 0, ONE);
    test_box(-ONE, 0, 0, 0, 0, 0);
    test_box(-ONE, 0, 0, -1, 0, 0);
    // negative normal picks the min corner
    load_col(COEFF_X, 2 * ONE, 0, 0, ONE);
    test_box(1, 0, 0, ONE, 0, 0);
    test_box(0, 0, 0, ONE, 0, 0);
    // extreme coefficients
    load_col(COEFF_X, MAXV, MINV, MAXV, MAXV);
    load_col(COEFF_Y, MINV, MINV, MINV, MINV);
    load_col(COEFF_Z, MAXV, MAXV, MINV, MINV);
    load_col(COEFF_W, MAXV, MINV, 0, MINV);
    test_box(MINV, MINV, MINV, MINV, MINV, MINV);
    test_box(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV);
    test_box(MINV, MINV, MINV, MAXV, MAXV, MAXV);
    test_box(MAXV, MAXV, MAXV, MINV, MINV, MINV);
    // identity frustum clips to the unit cube
    load_col(COEFF_X, ONE, 0, 0, 0);
    load_col(COEFF_Y, 0, ONE, 0, 0);
    load_col(COEFF_Z, 0, 0, ONE, 0);
    load_col(COEFF_W, 0, 0, 0, ONE);
    test_box(-ONE / 2, -ONE / 2, -ONE / 2, ONE / 2, ONE / 2, ONE / 2);
    test_box(2 * ONE, 0, 0, 3 * ONE, ONE / 2, ONE / 2);
    test_box(-5 * ONE, -5 * ONE, -5 * ONE, 5 * ONE, 5 * ONE, 5 * ONE);

    while (n_sent < ITEMS) begin
      if (n_sent >= ITEMS * 7 / 8) calm = 1'b1;
      random_matrix();
      n_tests = $urandom_range(10, 50);
      repeat (n_tests) random_box();
      if (!held && n_sent >= 500) begin
        // output held off while the sender keeps pushing
        held     = 1'b1;
        hold_req = 1'b1;
        rush     = 1'b1;
        repeat (80) random_box();
        rush     = 1'b0;
      end
      if (!drained && n_sent >= 1100) begin
        drained = 1'b1;
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (pending != 0);
      end
    end

    in_valid_i <= 1'b0;
    for (int i = 0; i < 5000 && pending != 0; i++) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (pending != 0) $error("visible: %0d expected results never arrived", pending);
    $display("%0d transactions: %0d column loads, %0d box tests (%0d visible, %0d culled)",
             n_sent, load_count, visible_count + culled_count, visible_count, culled_count);
    $display("output held off for %0d cycles once, pipeline drained once", HOLD_CYCLES);
    if (mismatch_count == 0 && pending == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
